@@ src/scbpa_pkg.sv @@
// Shared types and constants for the size-class block pool allocator.
package scbpa_pkg;

  localparam int unsigned SMALL_BYTES  = 16;
  localparam int unsigned MEDIUM_BYTES = 32;
  localparam int unsigned LARGE_BYTES  = 64;

  localparam int unsigned SMALL_SHIFT  = $clog2(SMALL_BYTES);
  localparam int unsigned MEDIUM_SHIFT = $clog2(MEDIUM_BYTES);
  localparam int unsigned LARGE_SHIFT  = $clog2(LARGE_BYTES);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  localparam logic [1:0] POOL_SMALL  = 2'd0;
  localparam logic [1:0] POOL_MEDIUM = 2'd1;
  localparam logic [1:0] POOL_LARGE  = 2'd2;

  localparam logic REG_AREA_BASE    = 1'b0;
  localparam logic REG_HEADER_BYTES = 1'b1;

  localparam logic [31:0] AREA_BASE_RESET    = 32'd0;
  localparam logic [3:0]  HEADER_BYTES_RESET = 4'd8;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
    logic [1:0]  pool_used;
  } rsp_t;

  // Decoder verdict: for an allocate, hit means a pool fits; for a free,
  // hit means the address lands on a block boundary.
  typedef struct packed {
    logic       is_free;
    logic       hit;
    logic [1:0] pool;
  } dec_t;

endpackage

@@ src/size_class_block_pool_allocator.sv @@
// Top level of the size-class block pool allocator: config, request and result registers.
//
// Usage:
//   Request channel: in_valid_i / in_stall_o with in_req_i (operation, request_size,
//   block_address). A request is taken on a clock edge with in_valid_i high and
//   in_stall_o low.
//   Result channel: out_valid_o / out_stall_i with out_rsp_o (result_address, status,
//   pool_used). Exactly one result per request, in request order.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i (0 area
//   base, 1 header bytes); write only while no request is in flight.
//   Flow: a request passes from the request register to the result register. One
//   request per cycle is sustained while out_stall_i is low: the head pop or push on
//   the free-list tables is done between the request and result registers.
//   Reset: every block is free, each pool list in ascending address order, area
//   base 0, header 8 bytes; both registers empty.
//   When the receiver stalls, the result register holds and one more request can
//   still be taken into the request register before in_stall_o rises.
module size_class_block_pool_allocator #(
  parameter int unsigned SMALL_COUNT  = 8,
  parameter int unsigned MEDIUM_COUNT = 8,
  parameter int unsigned LARGE_COUNT  = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  scbpa_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output scbpa_pkg::rsp_t  out_rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int unsigned TOTAL = SMALL_COUNT + MEDIUM_COUNT + LARGE_COUNT;
  localparam int unsigned BW    = $clog2(TOTAL);

  logic [31:0]     area_base_q;
  logic [3:0]      header_bytes_q;
  scbpa_pkg::req_t req_q;
  logic            req_vld_q;
  scbpa_pkg::rsp_t rsp_q;
  logic            rsp_vld_q;

  scbpa_pkg::dec_t dec;
  logic [BW-1:0]   dec_blk;
  scbpa_pkg::rsp_t rsp;
  logic            advance, fire, take;

  assign advance    = !rsp_vld_q || !out_stall_i;
  assign fire       = req_vld_q && advance;
  assign in_stall_o = req_vld_q && !advance;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_base_q    <= scbpa_pkg::AREA_BASE_RESET;
      header_bytes_q <= scbpa_pkg::HEADER_BYTES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        scbpa_pkg::REG_AREA_BASE:    area_base_q    <= cfg_data_i;
        scbpa_pkg::REG_HEADER_BYTES: header_bytes_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (take) begin
        req_vld_q <= 1'b1;
      end else if (fire) begin
        req_vld_q <= 1'b0;
      end
      if (advance) begin
        rsp_vld_q <= req_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp;
    end
  end

  scbpa_decode #(
    .SMALL_COUNT  (SMALL_COUNT),
    .MEDIUM_COUNT (MEDIUM_COUNT),
    .LARGE_COUNT  (LARGE_COUNT),
    .BW           (BW)
  ) u_decode (
    .req_i          (req_q),
    .area_base_i    (area_base_q),
    .header_bytes_i (header_bytes_q),
    .dec_o          (dec),
    .blk_o          (dec_blk)
  );

  scbpa_pools #(
    .SMALL_COUNT  (SMALL_COUNT),
    .MEDIUM_COUNT (MEDIUM_COUNT),
    .LARGE_COUNT  (LARGE_COUNT),
    .BW           (BW)
  ) u_pools (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .dec_i          (dec),
    .blk_i          (dec_blk),
    .area_base_i    (area_base_q),
    .header_bytes_i (header_bytes_q),
    .rsp_o          (rsp)
  );

  assign out_valid_o = rsp_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ src/scbpa_decode.sv @@
// Request decoder: size-class selection for allocates, address-to-block for frees.
module scbpa_decode #(
  parameter int unsigned SMALL_COUNT  = 8,
  parameter int unsigned MEDIUM_COUNT = 8,
  parameter int unsigned LARGE_COUNT  = 4,
  parameter int unsigned BW           = 5
) (
  input  scbpa_pkg::req_t   req_i,
  input  logic [31:0]       area_base_i,
  input  logic [3:0]        header_bytes_i,
  output scbpa_pkg::dec_t   dec_o,
  output logic [BW-1:0]     blk_o
);

  localparam logic [31:0] SPAN_S = 32'(SMALL_COUNT * scbpa_pkg::SMALL_BYTES);
  localparam logic [31:0] SPAN_M = 32'(MEDIUM_COUNT * scbpa_pkg::MEDIUM_BYTES);
  localparam logic [31:0] SPAN_L = 32'(LARGE_COUNT * scbpa_pkg::LARGE_BYTES);
  localparam logic [31:0] END_S  = SPAN_S;
  localparam logic [31:0] END_M  = SPAN_S + SPAN_M;
  localparam logic [31:0] END_L  = SPAN_S + SPAN_M + SPAN_L;
  localparam logic [BW-1:0] FIRST_M = BW'(SMALL_COUNT);
  localparam logic [BW-1:0] FIRST_L = BW'(SMALL_COUNT + MEDIUM_COUNT);

  logic [6:0]  lim_s, lim_m, lim_l;
  logic        fit_s, fit_m, fit_l;
  logic [31:0] off, rel_m, rel_l;

  always_comb begin
    lim_s = 7'(scbpa_pkg::SMALL_BYTES)  - {3'b0, header_bytes_i};
    lim_m = 7'(scbpa_pkg::MEDIUM_BYTES) - {3'b0, header_bytes_i};
    lim_l = 7'(scbpa_pkg::LARGE_BYTES)  - {3'b0, header_bytes_i};
    fit_s = req_i.request_size <= {9'b0, lim_s};
    fit_m = req_i.request_size <= {9'b0, lim_m};
    fit_l = req_i.request_size <= {9'b0, lim_l};

    off   = req_i.block_address - {28'b0, header_bytes_i} - area_base_i;
    rel_m = off - END_S;
    rel_l = off - END_M;

    dec_o.is_free = (req_i.operation == scbpa_pkg::OP_FREE);
    dec_o.hit     = 1'b0;
    dec_o.pool    = scbpa_pkg::POOL_SMALL;
    blk_o         = '0;

    if (req_i.operation == scbpa_pkg::OP_ALLOC) begin
      if (fit_s) begin
        dec_o.hit  = 1'b1;
        dec_o.pool = scbpa_pkg::POOL_SMALL;
      end else if (fit_m) begin
        dec_o.hit  = 1'b1;
        dec_o.pool = scbpa_pkg::POOL_MEDIUM;
      end else if (fit_l) begin
        dec_o.hit  = 1'b1;
        dec_o.pool = scbpa_pkg::POOL_LARGE;
      end
    end else begin
      if (off < END_S) begin
        if (off[scbpa_pkg::SMALL_SHIFT-1:0] == '0) begin
          dec_o.hit  = 1'b1;
          dec_o.pool = scbpa_pkg::POOL_SMALL;
          blk_o      = BW'(off >> scbpa_pkg::SMALL_SHIFT);
        end
      end else if (off < END_M) begin
        if (rel_m[scbpa_pkg::MEDIUM_SHIFT-1:0] == '0) begin
          dec_o.hit  = 1'b1;
          dec_o.pool = scbpa_pkg::POOL_MEDIUM;
          blk_o      = FIRST_M + BW'(rel_m >> scbpa_pkg::MEDIUM_SHIFT);
        end
      end else if (off < END_L) begin
        if (rel_l[scbpa_pkg::LARGE_SHIFT-1:0] == '0) begin
          dec_o.hit  = 1'b1;
          dec_o.pool = scbpa_pkg::POOL_LARGE;
          blk_o      = FIRST_L + BW'(rel_l >> scbpa_pkg::LARGE_SHIFT);
        end
      end
    end
  end

endmodule

@@ src/scbpa_pools.sv @@
// Free-list tables of the three pools with pop/push update and result forming.
module scbpa_pools #(
  parameter int unsigned SMALL_COUNT  = 8,
  parameter int unsigned MEDIUM_COUNT = 8,
  parameter int unsigned LARGE_COUNT  = 4,
  parameter int unsigned BW           = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  scbpa_pkg::dec_t   dec_i,
  input  logic [BW-1:0]     blk_i,
  input  logic [31:0]       area_base_i,
  input  logic [3:0]        header_bytes_i,
  output scbpa_pkg::rsp_t   rsp_o
);

  localparam int unsigned TOTAL = SMALL_COUNT + MEDIUM_COUNT + LARGE_COUNT;
  localparam logic [BW-1:0] FIRST_M = BW'(SMALL_COUNT);
  localparam logic [BW-1:0] FIRST_L = BW'(SMALL_COUNT + MEDIUM_COUNT);
  localparam logic [31:0] SPAN_S = 32'(SMALL_COUNT * scbpa_pkg::SMALL_BYTES);
  localparam logic [31:0] SPAN_M = 32'(MEDIUM_COUNT * scbpa_pkg::MEDIUM_BYTES);

  logic [BW-1:0]    head_q [3];
  logic [2:0]       empty_q;
  logic [BW-1:0]    next_q [TOTAL];
  logic [TOTAL-1:0] last_q;
  logic [TOTAL-1:0] alloc_q;

  logic [BW-1:0] head_blk, sel_blk;
  logic          pop, push, ok;
  logic [31:0]   blk_off;

  always_comb begin
    head_blk = head_q[dec_i.pool];
    sel_blk  = dec_i.is_free ? blk_i : head_blk;
    pop      = 1'b0;
    push     = 1'b0;
    rsp_o.result_address = '0;
    rsp_o.pool_used      = dec_i.pool;
    rsp_o.status         = scbpa_pkg::ST_OK;

    if (head_blk < FIRST_M) begin
      blk_off = 32'(head_blk) << scbpa_pkg::SMALL_SHIFT;
    end else if (head_blk < FIRST_L) begin
      blk_off = SPAN_S + (32'(head_blk - FIRST_M) << scbpa_pkg::MEDIUM_SHIFT);
    end else begin
      blk_off = SPAN_S + SPAN_M + (32'(head_blk - FIRST_L) << scbpa_pkg::LARGE_SHIFT);
    end

    if (!dec_i.is_free) begin
      if (!dec_i.hit) begin
        rsp_o.status    = scbpa_pkg::ST_NO_FIT;
        rsp_o.pool_used = scbpa_pkg::POOL_SMALL;
      end else if (empty_q[dec_i.pool]) begin
        rsp_o.status = scbpa_pkg::ST_EMPTY;
      end else begin
        pop = 1'b1;
        rsp_o.result_address = area_base_i + blk_off + {28'b0, header_bytes_i};
      end
    end else begin
      if (!dec_i.hit) begin
        rsp_o.status    = scbpa_pkg::ST_BAD_FREE;
        rsp_o.pool_used = scbpa_pkg::POOL_SMALL;
      end else if (!alloc_q[blk_i]) begin
        rsp_o.status = scbpa_pkg::ST_BAD_FREE;
      end else begin
        push = 1'b1;
      end
    end
    ok = pop || push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q[0] <= '0;
      head_q[1] <= FIRST_M;
      head_q[2] <= FIRST_L;
      empty_q   <= '0;
      alloc_q   <= '0;
      for (int b = 0; b < TOTAL; b++) begin
        if ((b == SMALL_COUNT - 1) || (b == SMALL_COUNT + MEDIUM_COUNT - 1) ||
            (b == TOTAL - 1)) begin
          next_q[b] <= BW'(b);
          last_q[b] <= 1'b1;
        end else begin
          next_q[b] <= BW'(b + 1);
          last_q[b] <= 1'b0;
        end
      end
    end else if (fire_i) begin
      if (pop) begin
        if (last_q[head_blk]) begin
          empty_q[dec_i.pool] <= 1'b1;
        end else begin
          head_q[dec_i.pool] <= next_q[head_blk];
        end
        alloc_q[head_blk] <= 1'b1;
      end else if (push) begin
        last_q[blk_i]       <= empty_q[dec_i.pool];
        next_q[blk_i]       <= empty_q[dec_i.pool] ? blk_i : head_blk;
        head_q[dec_i.pool]  <= blk_i;
        empty_q[dec_i.pool] <= 1'b0;
        alloc_q[blk_i]      <= 1'b0;
      end
    end
  end

  a_pop_marks_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && pop |=> alloc_q[$past(sel_blk)])
    else $error("popped block not marked allocated");

  a_push_refills_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && push |=> !empty_q[$past(dec_i.pool)] && !alloc_q[$past(sel_blk)])
    else $error("pushed block not returned to its pool");

  a_fail_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !ok |=> $stable(alloc_q) && $stable(empty_q))
    else $error("failed request changed pool state");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok |-> rsp_o.status == scbpa_pkg::ST_OK)
    else $error("committed request reports an error status");

endmodule
